>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define EFSA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("efsa assertion failed");

// Check a property on every rising clock edge, reset included
`define EFSA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("efsa assertion failed");

`endif

>>> rtl/efsa_pkg.sv
// Types and constants of the earliest-free server allocator
package efsa_pkg;

   localparam int MAX_SERVERS = 16;
   localparam int TIME_W      = 32;
   localparam int NUM_W       = 5;
   localparam int SRV_W       = 5;
   localparam int IDX_W       = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W       = $clog2(MAX_SERVERS + 1);

   localparam logic [NUM_W-1:0] NUM_SERVERS_RESET = NUM_W'(16);

   typedef struct packed {
      logic [TIME_W-1:0] arrival_time;
      logic [TIME_W-1:0] completion_time;
   } req_item_type;

   typedef struct packed {
      logic             accepted;
      logic [SRV_W-1:0] server_number;
   } rsp_item_type;

   // Control of the shared minimum tracker
   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctl_type;

   // Running result of the minimum tracker
   typedef struct packed {
      logic              found;
      logic [IDX_W-1:0]  idx;
      logic [TIME_W-1:0] best_time;
   } min_result_type;

endpackage

>>> rtl/earliest_free_server_allocator.sv
// Top level of the earliest-free server allocator
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_item (arrival_time, completion_time)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_item (accepted, server_number)
//   csr     | in        | csr_wr_en           | csr_wr_data (num_servers)
//
// An item is handled by a serial scan of the busy-until RAM through its single registered
// read port over the U opened servers within the limit (at most 16); when U is zero the
// scan is skipped and the block goes straight to its decision.
// Reset is synchronous and active high; it clears the opened count and sets the limit to 16.
// req_stall is high from acceptance until the result is loaded into the output register.
// A stalled result holds the block in its decision cycle only if a new result is ready.
module earliest_free_server_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  efsa_pkg::req_item_type        req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output efsa_pkg::rsp_item_type        rsp_item,
   input  logic                          csr_wr_en,
   input  logic [efsa_pkg::NUM_W-1:0]    csr_wr_data
);

   import efsa_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [TIME_W-1:0] arrival_ff, arrival_in;
   logic [TIME_W-1:0] completion_ff, completion_in;
   logic [CNT_W-1:0]  limit_ff, limit_in;
   logic [CNT_W-1:0]  usable_ff, usable_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]  opened_ff, opened_in;
   logic [NUM_W-1:0]  num_servers_ff, num_servers_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_item_type      rsp_item_ff, rsp_item_in;

   logic              req_accept;
   logic [CNT_W-1:0]  limit_now;
   logic [CNT_W-1:0]  usable_now;
   logic              last_issue;
   logic              out_free;
   logic              reuse;
   logic              open_new;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [TIME_W-1:0] rd_data;
   scan_ctl_type      scan_ctl;
   min_result_type    min_res;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   // Saturate the limit and clip the opened count to it
   always_comb begin
      if (32'(num_servers_ff) > 32'(MAX_SERVERS)) begin
         limit_now = CNT_W'(MAX_SERVERS);
      end else begin
         limit_now = CNT_W'(num_servers_ff);
      end
      usable_now = (opened_ff < limit_now) ? opened_ff : limit_now;
   end

   assign last_issue = ((CNT_W'(cnt_ff) + CNT_W'(1)) == usable_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Pick reuse, opening or rejection from the scan result
   assign reuse    = min_res.found && (min_res.best_time <= arrival_ff);
   assign open_new = !reuse && (opened_ff < limit_ff);
   assign wr_en    = (state_ff == ST_DECIDE) && out_free && (reuse || open_new);
   assign wr_addr  = reuse ? min_res.idx : opened_ff[IDX_W-1:0];

   assign scan_ctl.clear  = req_accept;
   assign scan_ctl.sample = rd_valid_ff;

   // Sequence the scan and the decision
   always_comb begin
      state_in       = state_ff;
      arrival_in     = arrival_ff;
      completion_in  = completion_ff;
      limit_in       = limit_ff;
      usable_in      = usable_ff;
      cnt_in         = cnt_ff;
      rd_valid_in    = 1'b0;
      rd_idx_in      = rd_idx_ff;
      opened_in      = opened_ff;
      num_servers_in = csr_wr_en ? csr_wr_data : num_servers_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_item_in    = rsp_item_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               arrival_in    = req_item.arrival_time;
               completion_in = req_item.completion_time;
               limit_in      = limit_now;
               usable_in     = usable_now;
               cnt_in        = '0;
               state_in      = (usable_now == '0) ? ST_DECIDE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_valid_in = 1'b1;
            rd_idx_in   = cnt_ff;
            cnt_in      = cnt_ff + IDX_W'(1);
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (reuse) begin
                  rsp_item_in.accepted      = 1'b1;
                  rsp_item_in.server_number = SRV_W'(32'(min_res.idx) + 32'd1);
               end else if (open_new) begin
                  rsp_item_in.accepted      = 1'b1;
                  rsp_item_in.server_number = SRV_W'(32'(opened_ff) + 32'd1);
                  opened_in                 = opened_ff + CNT_W'(1);
               end else begin
                  rsp_item_in.accepted      = 1'b0;
                  rsp_item_in.server_number = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rd_valid_ff    <= 1'b0;
         opened_ff      <= '0;
         num_servers_ff <= NUM_SERVERS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rd_valid_ff    <= rd_valid_in;
         opened_ff      <= opened_in;
         num_servers_ff <= num_servers_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      arrival_ff    <= arrival_in;
      completion_ff <= completion_in;
      limit_ff      <= limit_in;
      usable_ff     <= usable_in;
      cnt_ff        <= cnt_in;
      rd_idx_ff     <= rd_idx_in;
      rsp_item_ff   <= rsp_item_in;
   end

   // Busy-until times, one entry per server
   efsa_ram #(
      .WIDTH (TIME_W),
      .DEPTH (MAX_SERVERS)
   ) u_busy_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (completion_ff),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   // Earliest-time tracker fed by the scan
   efsa_min_unit u_min_unit (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .idx   (rd_idx_ff),
      .data  (rd_data),
      .res   (min_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> rtl/efsa_ram.sv
// Generic single-port-write, registered-read RAM
module efsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/efsa_min_unit.sv
// Shared compare unit that tracks the earliest busy-until time over a scan
module efsa_min_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  efsa_pkg::scan_ctl_type         ctl,
   input  logic [efsa_pkg::IDX_W-1:0]     idx,
   input  logic [efsa_pkg::TIME_W-1:0]    data,
   output efsa_pkg::min_result_type       res
);

   import efsa_pkg::*;

   logic              found_ff, found_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [TIME_W-1:0] best_ff, best_in;

   // Keep the first strictly smaller time, so ties go to the lowest index
   always_comb begin
      found_in = found_ff;
      idx_in   = idx_ff;
      best_in  = best_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.sample && (!found_ff || (data < best_ff))) begin
         found_in = 1'b1;
         idx_in   = idx;
         best_in  = data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      idx_ff  <= idx_in;
      best_ff <= best_in;
   end

   assign res.found     = found_ff;
   assign res.idx       = idx_ff;
   assign res.best_time = best_ff;

endmodule

>>> rtl/efsa_checker.sv
// Port-level checker for the earliest-free server allocator, bound to the top level
`include "assert_macros.svh"

module efsa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input efsa_pkg::req_item_type        req_item,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input efsa_pkg::rsp_item_type        rsp_item,
   input logic                          csr_wr_en,
   input logic [efsa_pkg::NUM_W-1:0]    csr_wr_data
);

   import efsa_pkg::*;

   // No result right after reset
   `EFSA_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> !rsp_valid)

   // One item at a time: the input stalls right after an accept
   `EFSA_ASSERT(a_stall_after_accept, clock, reset, (req_valid && !req_stall) |=> req_stall)

   // A rejected item reports server zero
   `EFSA_ASSERT(a_reject_zero, clock, reset, (rsp_valid && !rsp_item.accepted) |-> (rsp_item.server_number == '0))

   // An accepted item reports a real server
   `EFSA_ASSERT(a_accept_nonzero, clock, reset, (rsp_valid && rsp_item.accepted) |-> (rsp_item.server_number != '0))

   // A stalled result holds
   `EFSA_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_item)))

endmodule

bind earliest_free_server_allocator efsa_checker u_efsa_checker (.*);
